FILE: sv/ovnh_pkg.sv
// Shared constants, types and register codes for the octave value-noise height block.
package ovnh_pkg;

    localparam int MAX_OCTAVES = 16;
    localparam int FRAC_BITS   = 16;

    localparam int K_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
    localparam int W_W   = 31;
    localparam int FW    = FRAC_BITS + 1;
    localparam int SW_W  = 25;

    localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1 << 30);
    localparam logic [16:0]    PERS_ONE   = 17'd65536;

    localparam logic [31:0] HASH_Y = 32'd57;
    localparam logic [31:0] HASH_A = 32'd15731;
    localparam logic [31:0] HASH_B = 32'd789221;
    localparam logic [31:0] HASH_C = 32'd1376312589;
    localparam logic signed [31:0] LATTICE_ONE = 32'sd1073741824;

    typedef enum logic [2:0] {
        CFG_PERSISTENCE = 3'd0,
        CFG_BASE_FREQ   = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_OCTAVES     = 3'd3,
        CFG_SEED        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic           valid;
        logic           first;
        logic           last;
        logic           live;
        logic [K_W-1:0] k;
        logic [W_W-1:0] weight;
    } ctl_t;

endpackage

FILE: sv/octave_value_noise_height.sv
// Top level: fractal value-noise height, one octave per cycle through a deep pipeline.
//
// Usage
//   Requests: a coordinate pair (x_coord, y_coord) is taken at a clock edge with start
//   high and busy low. The sequencer then issues one octave per cycle into the
//   pipeline (octave_count clamped to 16; a single empty slot when it is zero);
//   busy stays high until the last octave of the request is issued. The next
//   request can then be taken, while earlier ones are still in flight.
//   Results: height is valid for one cycle with done high, once the last octave has
//   passed the octave stages, the accumulator, the gain multiply and saturation.
//   Results leave in request order. The receiver cannot stall; none is needed.
//   Pipeline: 17 octave stages (scale, offset, split, four hash stages, corners,
//   two blends, weight), an accumulator, then gain multiply and saturation.
//   Config: cfg_valid/cfg_ready write channel, always ready. Write only while idle.
//   Reset: control and config registers zero, pipeline empty, busy low; data not reset.
module octave_value_noise_height
    import ovnh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               done,
    output logic signed [31:0] height,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NSTG = 17;
    localparam int CW   = 38;
    localparam int DW   = CW + 1;
    localparam int VW   = 46;
    localparam int V2W  = 48;
    localparam int ACW  = 56;

    // configuration
    logic [16:0]        persistence_reg;
    logic [23:0]        base_freq_reg;
    logic signed [31:0] gain_reg;
    logic [4:0]         octave_count_reg;
    logic [15:0]        seed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persistence_reg  <= '0;
            base_freq_reg    <= '0;
            gain_reg         <= '0;
            octave_count_reg <= '0;
            seed_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PERSISTENCE:
                    persistence_reg <= (cfg_data[16:0] > PERS_ONE) ? PERS_ONE : cfg_data[16:0];
                CFG_BASE_FREQ: base_freq_reg    <= cfg_data[23:0];
                CFG_GAIN:      gain_reg         <= $signed(cfg_data);
                CFG_OCTAVES:   octave_count_reg <= cfg_data[4:0];
                CFG_SEED:      seed_reg         <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // octave sequencer
    ctl_t               ctl_reg [NSTG];
    ctl_t               ctl0_next;
    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_clamp;
    logic [31:0]        xc_reg;
    logic [31:0]        yc_reg;
    logic [K_W-1:0]     k_step;
    logic               last_step;
    logic [47:0]        wprod;

    assign busy = busy_reg;

    always_comb
    begin
        cnt_clamp = (int'(octave_count_reg) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES)
                                                           : CNT_W'(octave_count_reg);
        k_step    = ctl_reg[0].k + 1'b1;
        last_step = (CNT_W'(ctl_reg[0].k) + CNT_W'(2)) == cnt_reg;
        wprod     = ctl_reg[0].weight * persistence_reg;
        ctl0_next = ctl_reg[0];
        ctl0_next.valid = 1'b0;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            ctl0_next = '{valid: 1'b1, first: 1'b0, last: last_step, live: 1'b1,
                          k: k_step, weight: wprod[46:16]};
            busy_next = !last_step;
        end
        else if (start)
        begin
            ctl0_next = '{valid: 1'b1, first: 1'b1, last: (cnt_clamp <= CNT_W'(1)),
                          live: (cnt_clamp != '0), k: '0, weight: WEIGHT_ONE};
            busy_next = cnt_clamp > CNT_W'(1);
            cnt_next  = cnt_clamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int i = 0; i < NSTG; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            ctl_reg[0] <= ctl0_next;
            for (int i = 1; i < NSTG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            xc_reg <= x_coord;
            yc_reg <= y_coord;
        end
    end

    // coordinate scaling: axis a from y, axis b from x
    logic [31:0]           mag_a;
    logic [31:0]           mag_b;
    logic [55:0]           pa_reg;
    logic [55:0]           pb_reg;
    logic                  sa_reg;
    logic                  sb_reg;
    logic [95:0]           sha;
    logic [95:0]           shb;
    logic [63:0]           ua_reg;
    logic [63:0]           ub_reg;
    logic [63:0]           seed_ext;
    logic [63:0]           u2a_reg;
    logic [63:0]           u2b_reg;
    logic [63:0]           ma;
    logic [63:0]           mb;
    logic [31:0]           ipa_reg;
    logic [31:0]           ipb_reg;
    logic signed [FW-1:0]  fa_reg;
    logic signed [FW-1:0]  fb_reg;

    always_comb
    begin
        mag_a    = yc_reg[31] ? (~yc_reg + 32'd1) : yc_reg;
        mag_b    = xc_reg[31] ? (~xc_reg + 32'd1) : xc_reg;
        sha      = {40'd0, pa_reg} << ctl_reg[1].k;
        shb      = {40'd0, pb_reg} << ctl_reg[1].k;
        seed_ext = 64'(seed_reg) << FRAC_BITS;
        ma       = u2a_reg[63] ? (64'd0 - u2a_reg) : u2a_reg;
        mb       = u2b_reg[63] ? (64'd0 - u2b_reg) : u2b_reg;
    end

    always_ff @(posedge clk)
    begin
        pa_reg  <= mag_a * base_freq_reg;
        pb_reg  <= mag_b * base_freq_reg;
        sa_reg  <= yc_reg[31];
        sb_reg  <= xc_reg[31];
        ua_reg  <= sa_reg ? (64'd0 - sha[79:16]) : sha[79:16];
        ub_reg  <= sb_reg ? (64'd0 - shb[79:16]) : shb[79:16];
        u2a_reg <= ua_reg + seed_ext;
        u2b_reg <= ub_reg + seed_ext;
        ipa_reg <= u2a_reg[63] ? (32'd0 - ma[FRAC_BITS+31:FRAC_BITS])
                               : ma[FRAC_BITS+31:FRAC_BITS];
        ipb_reg <= u2b_reg[63] ? (32'd0 - mb[FRAC_BITS+31:FRAC_BITS])
                               : mb[FRAC_BITS+31:FRAC_BITS];
        fa_reg  <= u2a_reg[63] ? -$signed({1'b0, ma[FRAC_BITS-1:0]})
                               : $signed({1'b0, ma[FRAC_BITS-1:0]});
        fb_reg  <= u2b_reg[63] ? -$signed({1'b0, mb[FRAC_BITS-1:0]})
                               : $signed({1'b0, mb[FRAC_BITS-1:0]});
    end

    // 4x4 lattice, entry dy*4+dx
    logic signed [31:0] g_w [16];

    for (genvar dy = 0; dy < 4; dy++)
    begin : g_row
        for (genvar dx = 0; dx < 4; dx++)
        begin : g_col
            ovnh_lattice u_lattice (
                .clk (clk),
                .lx  (32'(ipa_reg + 32'(dx) - 32'd1)),
                .ly  (32'(ipb_reg + 32'(dy) - 32'd1)),
                .g   (g_w[dy*4+dx])
            );
        end
    end

    logic signed [SW_W-1:0] wx;
    logic signed [SW_W-1:0] wy;

    ovnh_smooth u_smooth_x (
        .clk  (clk),
        .frac (fa_reg),
        .w    (wx)
    );

    ovnh_smooth u_smooth_y (
        .clk  (clk),
        .frac (fb_reg),
        .w    (wy)
    );

    logic signed [SW_W-1:0] wxd_reg [3];
    logic signed [SW_W-1:0] wyd_reg [6];

    always_ff @(posedge clk)
    begin
        wxd_reg[0] <= wx;
        wyd_reg[0] <= wy;
        for (int i = 1; i < 3; i++)
        begin
            wxd_reg[i] <= wxd_reg[i-1];
        end
        for (int i = 1; i < 6; i++)
        begin
            wyd_reg[i] <= wyd_reg[i-1];
        end
    end

    // corners and blends
    function automatic logic signed [CW-1:0] corner_sum(
        input logic signed [31:0] gv [16],
        input int cx,
        input int cy
    );
        logic signed [CW-1:0] d;
        logic signed [CW-1:0] e;
        d = CW'(gv[(cy-1)*4+cx-1]) + CW'(gv[(cy-1)*4+cx+1])
          + CW'(gv[(cy+1)*4+cx-1]) + CW'(gv[(cy+1)*4+cx+1]);
        e = CW'(gv[cy*4+cx-1]) + CW'(gv[cy*4+cx+1])
          + CW'(gv[(cy-1)*4+cx]) + CW'(gv[(cy+1)*4+cx]);
        return d + (e <<< 1) + (CW'(gv[cy*4+cx]) <<< 2);
    endfunction

    logic signed [CW-1:0]     c11_reg;
    logic signed [CW-1:0]     c21_reg;
    logic signed [CW-1:0]     c12_reg;
    logic signed [CW-1:0]     c22_reg;
    logic signed [DW-1:0]     d1_reg;
    logic signed [DW-1:0]     d2_reg;
    logic signed [CW-1:0]     c11d_reg;
    logic signed [CW-1:0]     c12d_reg;
    logic signed [CW-1:0]     c11e_reg;
    logic signed [CW-1:0]     c12e_reg;
    logic signed [63:0]       p1_reg;
    logic signed [63:0]       p2_reg;
    logic signed [VW-1:0]     v1_reg;
    logic signed [VW-1:0]     v2_reg;
    logic signed [VW:0]       dv_reg;
    logic signed [VW-1:0]     v1d_reg;
    logic signed [VW-1:0]     v1e_reg;
    logic signed [VW+SW_W:0]  p3_reg;
    logic signed [V2W-1:0]    v_reg;
    logic signed [69:0]       pw_reg;
    logic signed [V2W-11:0]   vv;

    assign vv = v_reg[V2W-1:10];

    always_ff @(posedge clk)
    begin
        c11_reg  <= corner_sum(g_w, 1, 1);
        c21_reg  <= corner_sum(g_w, 2, 1);
        c12_reg  <= corner_sum(g_w, 1, 2);
        c22_reg  <= corner_sum(g_w, 2, 2);
        d1_reg   <= DW'(c21_reg) - DW'(c11_reg);
        d2_reg   <= DW'(c22_reg) - DW'(c12_reg);
        c11d_reg <= c11_reg;
        c12d_reg <= c12_reg;
        p1_reg   <= d1_reg * wxd_reg[2];
        p2_reg   <= d2_reg * wxd_reg[2];
        c11e_reg <= c11d_reg;
        c12e_reg <= c12d_reg;
        v1_reg   <= VW'(c11e_reg) + VW'(p1_reg >>> 20);
        v2_reg   <= VW'(c12e_reg) + VW'(p2_reg >>> 20);
        dv_reg   <= (VW+1)'(v2_reg) - (VW+1)'(v1_reg);
        v1d_reg  <= v1_reg;
        p3_reg   <= dv_reg * wyd_reg[5];
        v1e_reg  <= v1d_reg;
        v_reg    <= V2W'(v1e_reg) + V2W'(p3_reg >>> 20);
        pw_reg   <= vv * $signed({1'b0, ctl_reg[15].weight});
    end

    // accumulation, gain and saturation
    logic signed [ACW-1:0] acc_reg;
    logic signed [ACW-1:0] acc_next;
    logic signed [ACW-1:0] term;
    logic                  fin_valid_reg;
    logic signed [ACW-1:0] fin_sum_reg;
    logic                  gv_reg;
    logic signed [71:0]    gp_reg;
    logic signed [55:0]    hfull;
    logic                  done_reg;
    logic signed [31:0]    height_reg;

    always_comb
    begin
        term     = ctl_reg[16].live ? ACW'(pw_reg >>> 22) : '0;
        acc_next = (ctl_reg[16].first ? ACW'(0) : acc_reg) + term;
        hfull    = gp_reg[71:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            gv_reg        <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= ctl_reg[16].valid && ctl_reg[16].last;
            gv_reg        <= fin_valid_reg;
            done_reg      <= gv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg[16].valid)
        begin
            acc_reg <= acc_next;
        end
        fin_sum_reg <= acc_next;
        gp_reg      <= gain_reg * (fin_sum_reg >>> 16);
        if (hfull > 56'sd2147483647)
        begin
            height_reg <= 32'sh7fffffff;
        end
        else if (hfull < -56'sd2147483648)
        begin
            height_reg <= 32'sh80000000;
        end
        else
        begin
            height_reg <= hfull[31:0];
        end
    end

    assign done   = done_reg;
    assign height = height_reg;

`ifndef SYNTHESIS
    a_busy_issue: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ctl_reg[0].valid && !ctl_reg[0].last)
        else $error("busy without a pending octave");

    a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ctl_reg[0].valid && ctl_reg[0].first && ctl_reg[0].k == '0)
        else $error("request did not issue its first octave");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg |-> ##2 done)
        else $error("finished sum did not reach the output");
`endif

endmodule

FILE: sv/ovnh_lattice.sv
// Four-stage pipelined integer lattice hash for one grid point.
module ovnh_lattice
    import ovnh_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        lx,
    input  logic [31:0]        ly,
    output logic signed [31:0] g
);

    logic [31:0] mix;
    logic [31:0] n_next;
    logic [31:0] n_reg;
    logic [31:0] n1_reg;
    logic [31:0] n2_reg;
    logic [31:0] sq_reg;
    logic [31:0] t1_reg;
    logic [31:0] t2;
    logic signed [31:0] g_reg;

    assign mix    = 32'(lx + 32'(ly * HASH_Y));
    assign n_next = (mix << 13) ^ mix;
    assign t2     = 32'(32'(n2_reg * t1_reg) + HASH_C);

    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        sq_reg <= 32'(n_reg * n_reg);
        n1_reg <= n_reg;
        t1_reg <= 32'(32'(sq_reg * HASH_A) + HASH_B);
        n2_reg <= n1_reg;
        g_reg  <= LATTICE_ONE - $signed({1'b0, t2[30:0]});
    end

    assign g = g_reg;

endmodule

FILE: sv/ovnh_smooth.sv
// Three-stage pipelined smoothstep weight 3a^2 - 2a^3 in Q.20.
module ovnh_smooth
    import ovnh_pkg::*;
(
    input  logic                   clk,
    input  logic signed [FW-1:0]   frac,
    output logic signed [SW_W-1:0] w
);

    localparam int SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    logic signed [16:0]     a;
    logic signed [33:0]     a2_next;
    logic signed [33:0]     a2_reg;
    logic signed [16:0]     a_reg;
    logic signed [50:0]     a3_next;
    logic signed [50:0]     a3_reg;
    logic signed [51:0]     t3_next;
    logic signed [51:0]     t3_reg;
    logic signed [52:0]     wfull;
    logic signed [SW_W-1:0] w_reg;

    always_comb
    begin
        a       = 17'((frac >>> SHR) <<< SHL);
        a2_next = a * a;
        a3_next = a2_reg * a_reg;
        t3_next = a2_reg * 52'sd196608;
        wfull   = t3_reg - a3_reg - a3_reg;
    end

    always_ff @(posedge clk)
    begin
        a2_reg <= a2_next;
        a_reg  <= a;
        a3_reg <= a3_next;
        t3_reg <= t3_next;
        w_reg  <= wfull[52:28];
    end

    assign w = w_reg;

endmodule
